### rtl/bounded_sequence_deque_macros.svh
// Assertion helpers used by the deque module.
`ifndef BOUNDED_SEQUENCE_DEQUE_MACROS_SVH
`define BOUNDED_SEQUENCE_DEQUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed");

// The consequent must hold in the cycle after the antecedent.
`define BSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

### rtl/bsd_pkg.sv
`timescale 1ns / 1ps

package bsd_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int VALUE_W    = 32;
    localparam int OUT_CNT_W  = 5;
    localparam int ACTION_W   = 3;
    localparam int STATUS_W   = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_COUNT      = 3'd4,
        ACT_DELETE     = 3'd5,
        ACT_CLEAR      = 3'd6,
        ACT_DEDUP      = 3'd7
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_LEFT  = 2'd1,
        CELL_RIGHT = 2'd2,
        CELL_VALUE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t              op;
        logic [DATA_WIDTH-1:0] fill_data;
        logic [DATA_WIDTH-1:0] key;
    } cell_ctrl_t;

endpackage

### rtl/bounded_sequence_deque.sv
// Push and pop at either end and clear: result registered in the cycle after the word is accepted,
// and a new word may be accepted every cycle while out_ready is high.
// Count and delete: compare in the cell row into a registered match vector, then reduce it into the result.
// Dedup: one row step per cycle until the pointer reaches the fill level, then the result is registered.
// Reset (rst_n low, asynchronous) empties the sequence and drops any pending result.
`timescale 1ns / 1ps
`include "bounded_sequence_deque_macros.svh"

module bounded_sequence_deque
    import bsd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [ACTION_W-1:0]  action,
    input  logic signed [31:0]   value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATUS_W-1:0]  status,
    output logic signed [31:0]   popped_value,
    output logic [OUT_CNT_W-1:0] match_count,
    output logic [OUT_CNT_W-1:0] size_now,
    output logic                 seq_empty
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_COUNT  = 4'b0010,
        S_DELETE = 4'b0100,
        S_DEDUP  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [CNT_W-1:0]    ptr_reg, ptr_next;
    logic [DEPTH-1:0]    match_reg, match_next;
    logic                out_valid_reg, out_valid_next;
    status_t             status_reg, status_next;
    logic [VALUE_W-1:0]  popped_reg, popped_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    size_reg, size_next;
    logic                empty_reg, empty_next;

    logic                  in_fire;
    logic                  res_load;
    logic [DATA_WIDTH-1:0] value_w;
    logic [DATA_WIDTH-1:0] key;
    logic [DATA_WIDTH-1:0] cand;
    logic [CNT_W-1:0]      last_pos;
    logic                  is_full;
    logic                  dup;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    cell_op_t              cell_op   [DEPTH];
    cell_ctrl_t            cell_ctrl [DEPTH];
    logic [DEPTH-1:0]      eq_vec;
    logic [DEPTH-1:0]      valid_vec;
    logic [DEPTH-1:0]      below_ptr;
    logic [DEPTH-1:0]      past_first;

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;
    assign value_w  = DATA_WIDTH'(value);
    assign last_pos = fill_reg - CNT_W'(1);
    assign is_full  = (fill_reg >= CNT_W'(DEPTH));
    assign cand     = cell_data[ptr_reg[IDX_W-1:0]];
    assign key      = (state_reg == S_DEDUP) ? cand : value_w;
    assign dup      = |(eq_vec & below_ptr);

    for (genvar j = 0; j < DEPTH; j++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_w;
        logic [DATA_WIDTH-1:0] right_w;

        if (j == 0)
        begin : g_head
            assign left_w = value_w;
        end
        else
        begin : g_body_l
            assign left_w = cell_data[j-1];
        end

        if (j == DEPTH - 1)
        begin : g_tail
            assign right_w = cell_data[j];
        end
        else
        begin : g_body_r
            assign right_w = cell_data[j+1];
        end

        assign valid_vec[j]  = (CNT_W'(j) < fill_reg);
        assign below_ptr[j]  = (CNT_W'(j) < ptr_reg);
        // Set from the first matching position to the end of the row.
        assign past_first[j] = |match_reg[j:0];

        assign cell_ctrl[j].op        = cell_op[j];
        assign cell_ctrl[j].fill_data = value_w;
        assign cell_ctrl[j].key       = key;

        bsd_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl[j]),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[j]),
            .eq         (eq_vec[j])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        ptr_next       = ptr_reg;
        match_next     = match_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_load       = 1'b0;
        status_next    = ST_DONE;
        popped_next    = '0;
        count_next     = '0;
        for (int j = 0; j < DEPTH; j++)
        begin
            cell_op[j] = CELL_HOLD;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (action_t'(action))
                        ACT_PUSH_FRONT:
                        begin
                            res_load = 1'b1;
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                cell_op[0] = CELL_VALUE;
                                for (int j = 1; j < DEPTH; j++)
                                begin
                                    cell_op[j] = CELL_LEFT;
                                end
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                        ACT_PUSH_BACK:
                        begin
                            res_load = 1'b1;
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                for (int j = 0; j < DEPTH; j++)
                                begin
                                    if (CNT_W'(j) == fill_reg)
                                    begin
                                        cell_op[j] = CELL_VALUE;
                                    end
                                end
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                        ACT_POP_FRONT:
                        begin
                            res_load = 1'b1;
                            if (fill_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                popped_next = VALUE_W'(cell_data[0]);
                                for (int j = 0; j < DEPTH; j++)
                                begin
                                    cell_op[j] = CELL_RIGHT;
                                end
                                fill_next = last_pos;
                            end
                        end
                        ACT_POP_BACK:
                        begin
                            res_load = 1'b1;
                            if (fill_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                popped_next = VALUE_W'(cell_data[last_pos[IDX_W-1:0]]);
                                fill_next   = last_pos;
                            end
                        end
                        ACT_COUNT:
                        begin
                            match_next = eq_vec & valid_vec;
                            state_next = S_COUNT;
                        end
                        ACT_DELETE:
                        begin
                            match_next = eq_vec & valid_vec;
                            state_next = S_DELETE;
                        end
                        ACT_CLEAR:
                        begin
                            res_load  = 1'b1;
                            fill_next = '0;
                        end
                        ACT_DEDUP:
                        begin
                            ptr_next   = CNT_W'(1);
                            state_next = S_DEDUP;
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_COUNT:
            begin
                res_load   = 1'b1;
                count_next = CNT_W'($countones(match_reg));
                state_next = S_IDLE;
            end
            S_DELETE:
            begin
                res_load   = 1'b1;
                state_next = S_IDLE;
                if (|match_reg)
                begin
                    for (int j = 0; j < DEPTH; j++)
                    begin
                        if (past_first[j])
                        begin
                            cell_op[j] = CELL_RIGHT;
                        end
                    end
                    fill_next = last_pos;
                end
                else
                begin
                    status_next = ST_NOTFOUND;
                end
            end
            S_DEDUP:
            begin
                // Each step checks the word at ptr against every kept word before it.
                if (ptr_reg >= fill_reg)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
                else if (dup)
                begin
                    for (int j = 0; j < DEPTH; j++)
                    begin
                        if (!below_ptr[j])
                        begin
                            cell_op[j] = CELL_RIGHT;
                        end
                    end
                    fill_next = last_pos;
                end
                else
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        size_next  = fill_next;
        empty_next = (fill_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_reg <= match_next;
        if (res_load)
        begin
            status_reg <= status_next;
            popped_reg <= popped_next;
            count_reg  <= count_next;
            size_reg   <= size_next;
            empty_reg  <= empty_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign match_count  = OUT_CNT_W'(count_reg);
    assign size_now     = OUT_CNT_W'(size_reg);
    assign seq_empty    = empty_reg;

    `BSD_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= CNT_W'(DEPTH))
    `BSD_ASSERT_NOW(a_busy_no_result, state_reg != S_IDLE, !out_valid_reg)
    `BSD_ASSERT_NOW(a_full_size, out_valid_reg && status_reg == ST_FULL, size_reg == CNT_W'(DEPTH))
    `BSD_ASSERT_NOW(a_empty_size, out_valid_reg && status_reg == ST_EMPTY, empty_reg)

endmodule

### rtl/bsd_cell.sv
`timescale 1ns / 1ps

module bsd_cell
    import bsd_pkg::*;
(
    input  logic                  clk,
    input  cell_ctrl_t            ctrl,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] data,
    output logic                  eq
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        unique case (ctrl.op)
            CELL_HOLD:  data_next = data_reg;
            CELL_LEFT:  data_next = left_data;
            CELL_RIGHT: data_next = right_data;
            CELL_VALUE: data_next = ctrl.fill_data;
            default:    data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign eq   = (data_reg == ctrl.key);

endmodule
